### rtl/bpa_pkg.sv
// Shared types and constants for the bitmap page allocator.
package bpa_pkg;

    // Field widths of the stream and configuration ports.
    localparam int CmdW    = 1;
    localparam int ClassW  = 2;
    localparam int CountW  = 11;
    localparam int StartW  = 10;
    localparam int StatusW = 3;
    localparam int IndexW  = 10;
    localparam int CfgIdxW = 8;

    // Pages held in one map word.
    localparam int WordBits = 8;
    localparam int WordShift = 3;

    // Reset values of the quota registers.
    localparam logic [CountW-1:0] TcLimitReset   = 11'd1024;
    localparam logic [CountW-1:0] SwapLimitReset = 11'd1000;

    typedef enum logic [CfgIdxW-1:0] {
        REG_TC_LIMIT   = 8'd0,
        REG_SWAP_LIMIT = 8'd1
    } cfg_reg_t;

    typedef enum logic [CmdW-1:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [ClassW-1:0] {
        CLS_KERNEL = 2'd0,
        CLS_TC     = 2'd1,
        CLS_SWAP   = 2'd2,
        CLS_OTHER  = 2'd3
    } page_class_t;

    typedef enum logic [StatusW-1:0] {
        ST_OK      = 3'd0,
        ST_ZERO    = 3'd1,
        ST_QUOTA   = 3'd2,
        ST_NORUN   = 3'd3,
        ST_BADFREE = 3'd4
    } status_t;

    // Which walk over the map the sequencer is doing.
    typedef enum logic [1:0] {
        PASS_FIND,
        PASS_CHECK,
        PASS_MARK,
        PASS_CLEAR
    } pass_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_READ,
        S_EXAM,
        S_COUNT,
        S_DONE
    } state_t;

    // One map word: used, translation cache and swap bits of its pages.
    typedef struct packed {
        logic [WordBits-1:0] swap_tag;
        logic [WordBits-1:0] cache_tag;
        logic [WordBits-1:0] used;
    } map_word_t;

    // Write request into the page map.
    typedef struct packed {
        logic      en;
        map_word_t data;
    } map_wr_t;

endpackage

### rtl/bpa_map.sv
// Page map memory: one word of used and tag bits per row, with a valid bit per row.
module bpa_map #(
    parameter int NumWords = 128,
    parameter int AddrW    = 7
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [AddrW-1:0]     addr,
    input  bpa_pkg::map_wr_t     wr,
    output bpa_pkg::map_word_t   rd_data
);

    bpa_pkg::map_word_t mem [NumWords];
    bpa_pkg::map_word_t rd_word_reg;
    logic [NumWords-1:0] row_valid_reg;
    logic                rd_valid_reg;

    // Row valid bits: a row never written reads as all pages free.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            rd_valid_reg <= row_valid_reg[addr];
            if (wr.en) begin
                row_valid_reg[addr] <= 1'b1;
            end
        end
    end

    // Storage array with a registered read.
    always_ff @(posedge aclk) begin
        rd_word_reg <= mem[addr];
        if (wr.en) begin
            mem[addr] <= wr.data;
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

### rtl/bitmap_page_allocator_with_quotas_top.sv
// Top level of the bitmap first-fit page allocator with class quotas.
//
//  Channel  Ports                        Carries
//  in       s_tvalid/s_tready/s_tdata    one allocate or free request
//           s_tuser
//  out      m_tvalid/m_tready/m_tdata    one result per request
//           m_tuser
//  config   cfg_valid/cfg_ready          quota register writes
//           cfg_index/cfg_data
//
// The map is held as NUM_PAGES/8 words of eight pages; each word visit is a
// registered read, then examine and write back, through one memory port.
// An allocate walks from word 0 to the fitting run and then over the run's words;
// a free walks its range twice (check, then clear). Reset is synchronous and
// needs no clearing pass. One request is in flight; a finished result waits in
// the output register while the next request is taken.
module bitmap_page_allocator_with_quotas_top #(
    parameter int NUM_PAGES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // page_count[10:0], start_page[20:11], zero fill
    input  logic [2:0]  s_tuser,   // command[0], page_class[2:1]
    output logic        m_tvalid,
    input  logic        m_tready,
    // page_index[9:0], tc_used[20:10], swap_used[31:21], kernel_used[42:32], zero fill
    output logic [47:0] m_tdata,
    output logic [2:0]  m_tuser,   // status[2:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    localparam int NumWords = NUM_PAGES / bpa_pkg::WordBits;
    localparam int WaW      = (NumWords > 1) ? $clog2(NumWords) : 1;
    localparam int CntW     = $clog2(NUM_PAGES + 1);
    localparam int AW       = ((CntW > bpa_pkg::CountW) ? CntW : bpa_pkg::CountW) + 1;
    localparam logic [AW-1:0]  NpA      = AW'(NUM_PAGES);
    localparam logic [WaW-1:0] LastWord = WaW'(NumWords - 1);

    // Request fields.
    logic                        req_cmd;
    logic [bpa_pkg::ClassW-1:0]  req_cls;
    logic [bpa_pkg::CountW-1:0]  req_cnt;
    logic [bpa_pkg::StartW-1:0]  req_start;
    assign req_cnt   = s_tdata[10:0];
    assign req_start = s_tdata[20:11];
    assign req_cmd   = s_tuser[0];
    assign req_cls   = s_tuser[2:1];

    bpa_pkg::state_t state_reg, state_next;
    bpa_pkg::pass_t  pass_reg, pass_next;
    logic                       cmd_reg;
    logic [bpa_pkg::ClassW-1:0] cls_reg;
    logic [AW-1:0]              n_reg, lo_reg, lo_next, hi_reg, hi_next;
    logic [AW-1:0]              run_reg, run_next;
    logic [WaW-1:0]             wa_reg, wa_next;
    logic                       ftc_reg, ftc_next, fsw_reg, fsw_next;
    bpa_pkg::status_t           st_reg, st_next;
    logic [bpa_pkg::IndexW-1:0] idx_reg, idx_next;
    logic [bpa_pkg::CountW-1:0] tc_cnt_reg, tc_cnt_next;
    logic [bpa_pkg::CountW-1:0] sw_cnt_reg, sw_cnt_next;
    logic [bpa_pkg::CountW-1:0] kn_cnt_reg, kn_cnt_next;
    logic [bpa_pkg::CountW-1:0] tc_lim_reg, sw_lim_reg;
    logic                       out_valid_reg;
    logic [2:0]                 out_user_reg;
    logic [47:0]                out_data_reg;
    logic                       load_out;

    bpa_pkg::map_word_t rd_word;
    bpa_pkg::map_wr_t   wr;

    bpa_map #(
        .NumWords(NumWords),
        .AddrW   (WaW)
    ) u_map (
        .aclk   (aclk),
        .aresetn(aresetn),
        .addr   (wa_reg),
        .wr     (wr),
        .rd_data(rd_word)
    );

    assign s_tready  = (state_reg == bpa_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;

    // Per-word scratch for the combinational step.
    logic [AW-1:0]  base_p, p, run_v, fit_start, hi_m1;
    logic           fit_found, bad, wtc, wsw, cls_tc, cls_sw;
    logic [bpa_pkg::WordBits-1:0] mask;
    logic [WaW-1:0] end_word, lo_word;
    logic [AW:0]    tc_sum, sw_sum;
    logic [AW-1:0]  cnt_a, first_a;

    always_comb begin
        cnt_a   = AW'(req_cnt);
        first_a = AW'(req_start);
        cls_tc  = (cls_reg == bpa_pkg::CLS_TC);
        cls_sw  = (cls_reg == bpa_pkg::CLS_SWAP);
        base_p  = AW'({wa_reg, {bpa_pkg::WordShift{1'b0}}});
        hi_m1   = hi_reg - AW'(1);
        end_word = WaW'(hi_m1 >> bpa_pkg::WordShift);
        lo_word  = WaW'(lo_reg >> bpa_pkg::WordShift);
        tc_sum  = (AW+1)'(tc_cnt_reg) + (AW+1)'(n_reg);
        sw_sum  = (AW+1)'(sw_cnt_reg) + (AW+1)'(n_reg);

        // Run search over the eight pages of this word.
        run_v     = run_reg;
        fit_found = 1'b0;
        fit_start = '0;
        for (int j = 0; j < bpa_pkg::WordBits; j++) begin
            p = base_p + AW'(j);
            if (!fit_found) begin
                if (rd_word.used[j]) begin
                    run_v = '0;
                end else begin
                    run_v = run_v + AW'(1);
                    if (run_v == n_reg) begin
                        fit_found = 1'b1;
                        fit_start = p + AW'(1) - n_reg;
                    end
                end
            end
        end

        // Pages of this word inside the range, and the class of the first page.
        wtc = ftc_reg;
        wsw = fsw_reg;
        for (int j = 0; j < bpa_pkg::WordBits; j++) begin
            p = base_p + AW'(j);
            mask[j] = (p >= lo_reg) && (p < hi_reg);
            if (p == lo_reg) begin
                wtc = rd_word.cache_tag[j];
                wsw = !rd_word.cache_tag[j] && rd_word.swap_tag[j];
            end
        end

        // Consistency check of a free range.
        bad = 1'b0;
        for (int j = 0; j < bpa_pkg::WordBits; j++) begin
            if (mask[j]) begin
                if (!rd_word.used[j]) begin
                    bad = 1'b1;
                end else if (wtc) begin
                    if (!rd_word.cache_tag[j] || rd_word.swap_tag[j]) bad = 1'b1;
                end else if (wsw) begin
                    if (!rd_word.swap_tag[j] || rd_word.cache_tag[j]) bad = 1'b1;
                end else if (rd_word.cache_tag[j] || rd_word.swap_tag[j]) begin
                    bad = 1'b1;
                end
            end
        end

        // Defaults.
        state_next  = state_reg;
        pass_next   = pass_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        run_next    = run_reg;
        wa_next     = wa_reg;
        ftc_next    = ftc_reg;
        fsw_next    = fsw_reg;
        st_next     = st_reg;
        idx_next    = idx_reg;
        tc_cnt_next = tc_cnt_reg;
        sw_cnt_next = sw_cnt_reg;
        kn_cnt_next = kn_cnt_reg;
        wr.en       = 1'b0;
        wr.data     = rd_word;
        load_out    = 1'b0;

        case (state_reg)
            bpa_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    lo_next    = first_a;
                    hi_next    = first_a + cnt_a;
                    state_next = bpa_pkg::S_START;
                end
            end
            bpa_pkg::S_START: begin
                idx_next = '0;
                run_next = '0;
                state_next = bpa_pkg::S_DONE;
                if (cmd_reg == bpa_pkg::CMD_ALLOC) begin
                    if (cls_tc && tc_sum > (AW+1)'(tc_lim_reg)) begin
                        st_next = bpa_pkg::ST_QUOTA;
                    end else if (cls_sw && sw_sum > (AW+1)'(sw_lim_reg)) begin
                        st_next = bpa_pkg::ST_QUOTA;
                    end else if (n_reg == '0) begin
                        st_next = bpa_pkg::ST_ZERO;
                    end else if (n_reg > NpA) begin
                        st_next = bpa_pkg::ST_NORUN;
                    end else begin
                        pass_next  = bpa_pkg::PASS_FIND;
                        wa_next    = '0;
                        state_next = bpa_pkg::S_READ;
                    end
                end else begin
                    if (n_reg == '0) begin
                        st_next = bpa_pkg::ST_OK;
                    end else if (lo_reg >= NpA || n_reg > NpA - lo_reg) begin
                        st_next = bpa_pkg::ST_BADFREE;
                    end else begin
                        pass_next  = bpa_pkg::PASS_CHECK;
                        wa_next    = lo_word;
                        state_next = bpa_pkg::S_READ;
                    end
                end
            end
            bpa_pkg::S_READ: begin
                state_next = bpa_pkg::S_EXAM;
            end
            bpa_pkg::S_EXAM: begin
                state_next = bpa_pkg::S_READ;
                case (pass_reg)
                    bpa_pkg::PASS_FIND: begin
                        run_next = run_v;
                        if (fit_found) begin
                            lo_next   = fit_start;
                            hi_next   = fit_start + n_reg;
                            idx_next  = bpa_pkg::IndexW'(fit_start);
                            wa_next   = WaW'(fit_start >> bpa_pkg::WordShift);
                            pass_next = bpa_pkg::PASS_MARK;
                        end else if (wa_reg == LastWord) begin
                            st_next    = bpa_pkg::ST_NORUN;
                            state_next = bpa_pkg::S_DONE;
                        end else begin
                            wa_next = wa_reg + WaW'(1);
                        end
                    end
                    bpa_pkg::PASS_CHECK: begin
                        ftc_next = wtc;
                        fsw_next = wsw;
                        if (bad) begin
                            st_next    = bpa_pkg::ST_BADFREE;
                            state_next = bpa_pkg::S_DONE;
                        end else if (wa_reg == end_word) begin
                            state_next = bpa_pkg::S_COUNT;
                        end else begin
                            wa_next = wa_reg + WaW'(1);
                        end
                    end
                    bpa_pkg::PASS_MARK: begin
                        wr.en = 1'b1;
                        wr.data.used = rd_word.used | mask;
                        if (cls_tc) wr.data.cache_tag = rd_word.cache_tag | mask;
                        if (cls_sw) wr.data.swap_tag  = rd_word.swap_tag | mask;
                        if (wa_reg == end_word) begin
                            if (cls_tc) begin
                                tc_cnt_next = tc_cnt_reg + bpa_pkg::CountW'(n_reg);
                            end else if (cls_sw) begin
                                sw_cnt_next = sw_cnt_reg + bpa_pkg::CountW'(n_reg);
                            end else begin
                                kn_cnt_next = kn_cnt_reg + bpa_pkg::CountW'(n_reg);
                            end
                            st_next    = bpa_pkg::ST_OK;
                            state_next = bpa_pkg::S_DONE;
                        end else begin
                            wa_next = wa_reg + WaW'(1);
                        end
                    end
                    default: begin
                        // Clearing pass of a free.
                        wr.en = 1'b1;
                        wr.data.used      = rd_word.used & ~mask;
                        wr.data.cache_tag = rd_word.cache_tag & ~mask;
                        wr.data.swap_tag  = rd_word.swap_tag & ~mask;
                        if (wa_reg == end_word) begin
                            st_next    = bpa_pkg::ST_OK;
                            state_next = bpa_pkg::S_DONE;
                        end else begin
                            wa_next = wa_reg + WaW'(1);
                        end
                    end
                endcase
            end
            bpa_pkg::S_COUNT: begin
                // Class counter check, then the counter update and the clearing pass.
                state_next = bpa_pkg::S_READ;
                pass_next  = bpa_pkg::PASS_CLEAR;
                wa_next    = lo_word;
                if (ftc_reg) begin
                    if (n_reg > AW'(tc_cnt_reg)) begin
                        st_next    = bpa_pkg::ST_BADFREE;
                        state_next = bpa_pkg::S_DONE;
                    end else begin
                        tc_cnt_next = tc_cnt_reg - bpa_pkg::CountW'(n_reg);
                    end
                end else if (fsw_reg) begin
                    if (n_reg > AW'(sw_cnt_reg)) begin
                        st_next    = bpa_pkg::ST_BADFREE;
                        state_next = bpa_pkg::S_DONE;
                    end else begin
                        sw_cnt_next = sw_cnt_reg - bpa_pkg::CountW'(n_reg);
                    end
                end else begin
                    if (n_reg > AW'(kn_cnt_reg)) begin
                        st_next    = bpa_pkg::ST_BADFREE;
                        state_next = bpa_pkg::S_DONE;
                    end else begin
                        kn_cnt_next = kn_cnt_reg - bpa_pkg::CountW'(n_reg);
                    end
                end
            end
            bpa_pkg::S_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = bpa_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bpa_pkg::S_IDLE;
            end
        endcase
    end

    // Control state, counters and quota registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bpa_pkg::S_IDLE;
            pass_reg      <= bpa_pkg::PASS_FIND;
            tc_cnt_reg    <= '0;
            sw_cnt_reg    <= '0;
            kn_cnt_reg    <= '0;
            tc_lim_reg    <= bpa_pkg::TcLimitReset;
            sw_lim_reg    <= bpa_pkg::SwapLimitReset;
            out_valid_reg <= 1'b0;
            wa_reg        <= '0;
        end else begin
            state_reg  <= state_next;
            pass_reg   <= pass_next;
            tc_cnt_reg <= tc_cnt_next;
            sw_cnt_reg <= sw_cnt_next;
            kn_cnt_reg <= kn_cnt_next;
            wa_reg     <= wa_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == bpa_pkg::REG_TC_LIMIT) begin
                    tc_lim_reg <= cfg_data;
                end else if (cfg_index == bpa_pkg::REG_SWAP_LIMIT) begin
                    sw_lim_reg <= cfg_data;
                end
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request and result payload.
    always_ff @(posedge aclk) begin
        run_reg <= run_next;
        ftc_reg <= ftc_next;
        fsw_reg <= fsw_next;
        st_reg  <= st_next;
        idx_reg <= idx_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        if (s_tvalid && s_tready) begin
            cmd_reg <= req_cmd;
            cls_reg <= req_cls;
            n_reg   <= cnt_a;
        end
        if (load_out) begin
            out_user_reg <= st_reg;
            out_data_reg <= {5'd0, kn_cnt_reg, sw_cnt_reg, tc_cnt_reg, idx_reg};
        end
    end

endmodule
